### rtl/tdr_pkg.sv
// shared types and constants of the task dependency release block
package tdr_pkg;

  localparam int CMD_W   = 2;
  localparam int ID_W    = 10;
  localparam int CLU_W   = 3;
  localparam int START_W = 12;
  localparam int CNT_W   = 7;
  localparam int KIND_W  = 4;
  localparam int IDX_W   = 12;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_TASK = 2'd0,
    CMD_LOAD_SUCC = 2'd1,
    CMD_DONE      = 2'd2,
    CMD_NONE      = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [CNT_W-1:0]   count;
    logic [KIND_W-1:0]  kind;
  } task_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TASK,
    ST_REDUCE,
    ST_LIST,
    ST_PEND
  } walk_state_t;

  // memory accesses requested by the walker
  typedef struct packed {
    logic task_rd;
    logic list_rd;
    logic pend_rd;
    logic pend_wr;
  } mem_req_t;

endpackage

### rtl/tdr_if.sv
// command and result channel interfaces
interface tdr_cmd_if import tdr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [ID_W-1:0]    task_id;
  logic [CLU_W-1:0]   done_cluster;
  logic [START_W-1:0] succ_start;
  logic [CNT_W-1:0]   succ_count;
  logic [CNT_W-1:0]   pred_count;
  logic [KIND_W-1:0]  task_kind;
  logic [IDX_W-1:0]   list_index;
  logic [ID_W-1:0]    successor_id;

  modport source (
    output valid, command, task_id, done_cluster, succ_start, succ_count, pred_count,
           task_kind, list_index, successor_id,
    input  ready
  );
  modport sink (
    input  valid, command, task_id, done_cluster, succ_start, succ_count, pred_count,
           task_kind, list_index, successor_id,
    output ready
  );
endinterface

interface tdr_res_if import tdr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ID_W-1:0]   successor_task;
  logic              became_ready;
  logic [KIND_W-1:0] ready_kind;
  logic [CLU_W-1:0]  target_cluster;
  logic              last;

  modport source (
    output valid, successor_task, became_ready, ready_kind, target_cluster, last,
    input  ready
  );
  modport sink (
    input  valid, successor_task, became_ready, ready_kind, target_cluster, last,
    output ready
  );
endinterface

### rtl/task_dependency_release_core.sv
// top level of the task dependency release block
// Usage: one command channel (cmd) and one result channel (res), both valid/ready.
// Command 0 loads a task entry (successor start, successor count, pending predecessor
// count, kind), command 1 writes one successor list position, command 2 reports a
// finished task and the cluster that finished it. Command 3 is ignored.
// Loads and ignored commands give no result and start no walk.
// A completion reads the task entry, then visits each successor in list
// order: list read, then count and kind read, then count write and result load,
// paced by the registered read of the list and count memories.
// A completion holds cmd.ready low until its walk ends; a start position reduction
// comes first when the stored start is at or beyond the list depth.
// A stalled receiver holds the result register; the walk waits in its update step,
// so no count is written twice. The last result of a completion may still wait while
// the next command is accepted.
// Reset clears the sequencer and the result valid only; the tables and the successor
// list hold nothing meaningful until loaded.
module task_dependency_release_core import tdr_pkg::*; #(
  parameter int TASK_SLOTS     = 1024,
  parameter int LIST_DEPTH     = 4096,
  parameter int CLUSTERS       = 8,
  parameter int MAX_SUCCESSORS = 64,
  parameter int KINDS          = 16
) (
  input  logic      clk,
  input  logic      rst,
  tdr_cmd_if.sink   cmd,
  tdr_res_if.source res
);

  localparam int TAW = $clog2(TASK_SLOTS);
  localparam int LAW = $clog2(LIST_DEPTH);

  logic              walk_idle;
  logic              cmd_acc;
  logic              tid_ok, idx_ok;
  logic              load_task, load_succ, done_go;
  mem_req_t          walk_req;
  logic [LAW-1:0]    walk_list_addr;
  logic [TAW-1:0]    walk_ent_addr;
  logic [CNT_W-1:0]  walk_pend_wdata;

  task_entry_t       task_wdata, task_q;
  logic [CNT_W-1:0]  pend_q;
  logic [ID_W-1:0]   list_q;
  logic [CNT_W-1:0]  cnt_clamped;
  logic [KIND_W-1:0] kind_clamped;

  // commands are taken only while no walk is in progress
  assign cmd.ready = walk_idle;
  assign cmd_acc   = cmd.valid && cmd.ready;

  // range checks against the configured table sizes
  assign tid_ok = 32'(cmd.task_id) < 32'(TASK_SLOTS);
  assign idx_ok = 32'(cmd.list_index) < 32'(LIST_DEPTH);

  // command decode
  always_comb begin
    load_task = 1'b0;
    load_succ = 1'b0;
    done_go   = 1'b0;
    case (cmd_t'(cmd.command))
      CMD_LOAD_TASK: load_task = cmd_acc && tid_ok;
      CMD_LOAD_SUCC: load_succ = cmd_acc && idx_ok;
      CMD_DONE:      done_go   = cmd_acc && tid_ok;
      default: begin
      end
    endcase
  end

  // successor count and kind are clamped on the way into the table
  assign cnt_clamped  = (32'(cmd.succ_count) > 32'(MAX_SUCCESSORS)) ?
                        CNT_W'(MAX_SUCCESSORS) : cmd.succ_count;
  assign kind_clamped = (32'(cmd.task_kind) >= 32'(KINDS)) ?
                        KIND_W'(KINDS - 1) : cmd.task_kind;

  always_comb begin
    task_wdata.start = cmd.succ_start;
    task_wdata.count = cnt_clamped;
    task_wdata.kind  = kind_clamped;
  end

  // task entry table: start, count and kind, read by the completion and for successor kinds
  tdr_ram #(
    .WIDTH ($bits(task_entry_t)),
    .DEPTH (TASK_SLOTS)
  ) u_task_ram (
    .clk   (clk),
    .we    (load_task),
    .waddr (TAW'(cmd.task_id)),
    .wdata (task_wdata),
    .re    (done_go || walk_req.task_rd),
    .raddr (walk_idle ? TAW'(cmd.task_id) : walk_ent_addr),
    .rdata (task_q)
  );

  // pending predecessor counts: written by loads and by the walk's decrement
  tdr_ram #(
    .WIDTH (CNT_W),
    .DEPTH (TASK_SLOTS)
  ) u_pend_ram (
    .clk   (clk),
    .we    (load_task || walk_req.pend_wr),
    .waddr (load_task ? TAW'(cmd.task_id) : walk_ent_addr),
    .wdata (load_task ? cmd.pred_count : walk_pend_wdata),
    .re    (walk_req.pend_rd),
    .raddr (walk_ent_addr),
    .rdata (pend_q)
  );

  // shared successor list
  tdr_ram #(
    .WIDTH (ID_W),
    .DEPTH (LIST_DEPTH)
  ) u_list_ram (
    .clk   (clk),
    .we    (load_succ),
    .waddr (LAW'(cmd.list_index)),
    .wdata (cmd.successor_id),
    .re    (walk_req.list_rd),
    .raddr (walk_list_addr),
    .rdata (list_q)
  );

  // walk sequencer and result register
  tdr_walk #(
    .TASK_SLOTS (TASK_SLOTS),
    .LIST_DEPTH (LIST_DEPTH),
    .CLUSTERS   (CLUSTERS)
  ) u_walk (
    .clk        (clk),
    .rst        (rst),
    .start      (done_go),
    .cluster_in (cmd.done_cluster),
    .task_q     (task_q),
    .list_q     (list_q),
    .pend_q     (pend_q),
    .idle       (walk_idle),
    .req        (walk_req),
    .list_addr  (walk_list_addr),
    .ent_addr   (walk_ent_addr),
    .pend_wdata (walk_pend_wdata),
    .res        (res)
  );

`ifndef SYNTHESIS
  // a load never collides with a count write from the walk
  a_no_pend_collision: assert property (@(posedge clk) disable iff (rst)
    !(load_task && walk_req.pend_wr))
    else $error("pending count write collision");

  // an accepted completion blocks the command channel on the next cycle
  a_busy_after_done: assert property (@(posedge clk) disable iff (rst)
    done_go |=> !cmd.ready)
    else $error("command taken during a walk");

  // a result that is not ready carries no target cluster
  a_cluster_zero: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.became_ready) |-> (res.target_cluster == '0))
    else $error("cluster set on a non-ready result");

  // the walk only reads counts of in-range successors
  a_pend_rd_range: assert property (@(posedge clk) disable iff (rst)
    walk_req.pend_rd |-> (32'(walk_ent_addr) < 32'(TASK_SLOTS)))
    else $error("count read out of range");
`endif

endmodule

### rtl/tdr_ram.sv
// generic single write port ram with registered read
module tdr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/tdr_walk.sv
// successor walk sequencer: start position reduce, list walk, count update, result register
module tdr_walk import tdr_pkg::*; #(
  parameter int TASK_SLOTS = 1024,
  parameter int LIST_DEPTH = 4096,
  parameter int CLUSTERS   = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [CLU_W-1:0]              cluster_in,
  input  task_entry_t                   task_q,
  input  logic [ID_W-1:0]               list_q,
  input  logic [CNT_W-1:0]              pend_q,
  output logic                          idle,
  output mem_req_t                      req,
  output logic [$clog2(LIST_DEPTH)-1:0] list_addr,
  output logic [$clog2(TASK_SLOTS)-1:0] ent_addr,
  output logic [CNT_W-1:0]              pend_wdata,
  tdr_res_if.source                     res
);

  localparam int LAW       = $clog2(LIST_DEPTH);
  localparam int TAW       = $clog2(TASK_SLOTS);
  localparam int CLU_STEPS = 1 << CLU_W;
  // reciprocal of the list depth, exact for every start value
  localparam int RED_D     = (LIST_DEPTH < (1 << START_W)) ? LIST_DEPTH : (1 << START_W);
  localparam int RED_S     = START_W + $clog2(RED_D);
  localparam int RED_M     = ((1 << RED_S) + RED_D - 1) / RED_D;

  walk_state_t        state, state_next;
  logic [LAW-1:0]     pos, pos_nx;
  logic [LAW:0]       pos_inc;
  logic [CNT_W-1:0]   left;
  logic [START_W-1:0] rem, rem_nx;
  logic [START_W-1:0] quo;
  logic [31:0]        quo_full;
  logic               step;
  logic [CLU_W-1:0]   clu, clu_r;
  logic [ID_W-1:0]    succ;
  logic               succ_ok, list_ok;
  logic               start_wrap, dec, rdy, out_load;
  logic               out_valid;

  // cluster id modulo cluster count, by repeated subtract on a narrow value
  always_comb begin
    clu_r = cluster_in;
    for (int i = 0; i < CLU_STEPS; i++) begin
      if (32'(clu_r) >= 32'(CLUSTERS)) begin
        clu_r = clu_r - CLU_W'(CLUSTERS);
      end
    end
  end

  // start modulo list depth: quotient by reciprocal multiply, then subtract
  always_comb begin
    quo_full = 32'(rem) * 32'(RED_M);
    rem_nx   = rem - START_W'(32'(quo) * 32'(RED_D));
  end

  always_comb begin
    pos_inc = {1'b0, pos} + (LAW+1)'(1);
    pos_nx  = (pos_inc == (LAW+1)'(LIST_DEPTH)) ? '0 : pos_inc[LAW-1:0];
  end

  assign start_wrap = 32'(task_q.start) >= 32'(LIST_DEPTH);
  assign list_ok    = 32'(list_q) < 32'(TASK_SLOTS);
  assign dec        = succ_ok && (pend_q != '0);
  assign rdy        = dec && (pend_q == CNT_W'(1));
  assign pend_wdata = pend_q - CNT_W'(1);
  assign idle       = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req        = '0;
    list_addr  = pos;
    ent_addr   = TAW'(succ);
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_TASK;
        end
      end
      ST_TASK: begin
        if (task_q.count == '0) begin
          state_next = ST_IDLE;
        end else if (start_wrap) begin
          state_next = ST_REDUCE;
        end else begin
          req.list_rd = 1'b1;
          list_addr   = LAW'(task_q.start);
          state_next  = ST_LIST;
        end
      end
      ST_REDUCE: begin
        if (step) begin
          req.list_rd = 1'b1;
          list_addr   = LAW'(rem_nx);
          state_next  = ST_LIST;
        end
      end
      ST_LIST: begin
        ent_addr = TAW'(list_q);
        if (list_ok) begin
          req.task_rd = 1'b1;
          req.pend_rd = 1'b1;
        end
        state_next = ST_PEND;
      end
      ST_PEND: begin
        if (!out_valid || res.ready) begin
          out_load    = 1'b1;
          req.pend_wr = dec;
          if (left == CNT_W'(1)) begin
            state_next = ST_IDLE;
          end else begin
            req.list_rd = 1'b1;
            list_addr   = pos_nx;
            state_next  = ST_LIST;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // walk datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          clu <= clu_r;
        end
      end
      ST_TASK: begin
        left <= task_q.count;
        rem  <= task_q.start;
        step <= 1'b0;
        pos  <= LAW'(task_q.start);
      end
      ST_REDUCE: begin
        step <= 1'b1;
        if (!step) begin
          quo <= START_W'(quo_full >> RED_S);
        end else begin
          pos <= LAW'(rem_nx);
        end
      end
      ST_LIST: begin
        succ    <= list_q;
        succ_ok <= list_ok;
      end
      ST_PEND: begin
        if (out_load) begin
          left <= left - CNT_W'(1);
          pos  <= pos_nx;
        end
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res.successor_task <= succ;
      res.became_ready   <= rdy;
      res.ready_kind     <= succ_ok ? task_q.kind : '0;
      res.target_cluster <= rdy ? clu : '0;
      res.last           <= (left == CNT_W'(1));
    end
  end

  assign res.valid = out_valid;

endmodule
